// ----- rtl/fwd_kin_vel_6r_wrist_arm_top_defines.svh -----
`ifndef FWD_KIN_VEL_6R_WRIST_ARM_TOP_DEFINES_SVH
`define FWD_KIN_VEL_6R_WRIST_ARM_TOP_DEFINES_SVH

// Both macros sample on the rising edge of clk_i and are off while rst_ni is low.
`define FKV_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fkv check failed");

`define FKV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fkv check failed");

`endif

// ----- rtl/fkv_pkg.sv -----
package fkv_pkg;

  localparam int unsigned ANGLE_BITS_DEF      = 16;
  localparam int unsigned TRIG_ITERATIONS_DEF = 16;
  localparam int unsigned ITEM_CYCLES         = 6;
  localparam int unsigned KIN_STAGES          = 6;

  localparam logic signed [33:0] KINV30 = 34'sd652032874;
  localparam logic signed [33:0] ONE30  = 34'sd1073741824;

  localparam logic [31:0] ATAN_PHASE [30] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef logic signed [63:0] w_t;

  localparam w_t SAT_MAX = 64'sd2147483647;
  localparam w_t SAT_MIN = -64'sd2147483648;

  typedef enum logic [2:0] {
    CFG_BASE_HEIGHT      = 3'd0,
    CFG_UPPER_ARM_LENGTH = 3'd1,
    CFG_FOREARM_LENGTH   = 3'd2,
    CFG_TOOL_LENGTH      = 3'd3,
    CFG_REACH_LIMIT_SQ   = 3'd4,
    CFG_EPS_OVER_BASE    = 3'd5,
    CFG_EPS_EXTENDED     = 3'd6,
    CFG_EPS_WRIST_PAR    = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    KIND_ROT0 = 3'd0,
    KIND_ROT1 = 3'd1,
    KIND_ROT2 = 3'd2,
    KIND_POS  = 3'd3,
    KIND_LIN  = 3'd4,
    KIND_ANG  = 3'd5
  } kind_e;

  typedef struct packed {
    logic [30:0] base_height;
    logic [30:0] upper_arm_length;
    logic [30:0] forearm_length;
    logic [30:0] tool_length;
    logic [62:0] reach_limit_sq;
    logic [30:0] eps_over_base;
    logic [30:0] eps_extended;
    logic [30:0] eps_wrist_parallel;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] rate_1;
    logic signed [31:0] rate_2;
    logic signed [31:0] rate_3;
    logic signed [31:0] rate_4;
    logic signed [31:0] rate_5;
    logic signed [31:0] rate_6;
  } jnt_rate_t;

  typedef struct packed {
    logic signed [15:0] angle_1;
    logic signed [15:0] angle_2;
    logic signed [15:0] angle_3;
    logic signed [15:0] angle_4;
    logic signed [15:0] angle_5;
    logic signed [15:0] angle_6;
    logic signed [31:0] rate_1;
    logic signed [31:0] rate_2;
    logic signed [31:0] rate_3;
    logic signed [31:0] rate_4;
    logic signed [31:0] rate_5;
    logic signed [31:0] rate_6;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         item_kind;
    logic signed [31:0] comp_x;
    logic signed [31:0] comp_y;
    logic signed [31:0] comp_z;
    logic [6:0]         status_bits;
    logic               singular;
    logic               last;
  } res_t;

  typedef struct packed {
    logic signed [31:0] c1, s1, c2, s2, c23, s23, c4, s4, c5, s5, c6, s6;
  } trig_t;

  typedef struct packed {
    trig_t     trig;
    jnt_rate_t rate;
    logic      flip;
    logic      elbow;
  } kin_in_t;

  typedef struct packed {
    logic signed [31:0] x, y, z;
  } vec3_t;

  typedef struct packed {
    vec3_t [5:0] item;
    logic [6:0]  status;
  } kin_res_t;

  function automatic w_t sat32(w_t v);
    if (v > SAT_MAX) return SAT_MAX;
    if (v < SAT_MIN) return SAT_MIN;
    return v;
  endfunction

  function automatic w_t mul30(w_t a, w_t b);
    w_t p;
    p = a * b + (w_t'(1) <<< 29);
    return p >>> 30;
  endfunction

  function automatic w_t mul16(w_t a, w_t b);
    w_t p;
    p = a * b + (w_t'(1) <<< 15);
    return p >>> 16;
  endfunction

  function automatic w_t absw(w_t v);
    return (v < 0) ? -v : v;
  endfunction

endpackage

// ----- rtl/fwd_kin_vel_6r_wrist_arm_top.sv -----
// Channel    | Direction | Handshake                         | Payload
// command    | in        | start high while busy low         | cmd_i
// result     | out       | res_strobe_o, one cycle per item  | res_o
// config     | in        | cfg_we_i, no wait                 | cfg_idx_i, cfg_data_i
//
// A command is taken only while busy is low and yields six result transactions on
// consecutive cycles. Each command passes through six sine and cosine lanes
// of TRIG_ITERATIONS + 2 stages each, six kinematics stages, a hold register
// and the output register.
// Reset clears the control registers and the configuration to zero.
// The receiver cannot stall; later commands overlap the work of earlier ones.
`include "fwd_kin_vel_6r_wrist_arm_top_defines.svh"

module fwd_kin_vel_6r_wrist_arm_top #(
  parameter int unsigned ANGLE_BITS      = fkv_pkg::ANGLE_BITS_DEF,
  parameter int unsigned TRIG_ITERATIONS = fkv_pkg::TRIG_ITERATIONS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  fkv_pkg::cmd_t  cmd_i,
  output logic           busy,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [62:0]    cfg_data_i,
  output logic           res_strobe_o,
  output fkv_pkg::res_t  res_o
);
  import fkv_pkg::*;

  localparam int unsigned CordicLat = TRIG_ITERATIONS + 2;
  localparam int unsigned Lanes     = 6;

  typedef struct packed {
    jnt_rate_t rate;
    logic      flip;
    logic      elbow;
  } dly_t;

  cfg_t              cfg_q;
  logic [2:0]        gap_q;
  logic              accept;
  logic [31:0]       ph [Lanes];
  logic [31:0]       lane_ph [Lanes];
  logic signed [31:0] cos_w [Lanes];
  logic signed [31:0] sin_w [Lanes];
  dly_t              dly_d;
  dly_t              dly_q [CordicLat];
  logic [CordicLat-1:0] dvld_q;
  kin_in_t           kin_in;
  logic              kin_vld;
  kin_res_t          kin_res;
  kin_res_t          hold_q;
  logic [2:0]        cnt_q;
  logic              act_q;
  res_t              res_q;
  logic              strobe_q;

  assign accept = start && !busy;
  assign busy   = gap_q != '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_BASE_HEIGHT:      cfg_q.base_height        <= cfg_data_i[30:0];
        CFG_UPPER_ARM_LENGTH: cfg_q.upper_arm_length   <= cfg_data_i[30:0];
        CFG_FOREARM_LENGTH:   cfg_q.forearm_length     <= cfg_data_i[30:0];
        CFG_TOOL_LENGTH:      cfg_q.tool_length        <= cfg_data_i[30:0];
        CFG_REACH_LIMIT_SQ:   cfg_q.reach_limit_sq     <= cfg_data_i;
        CFG_EPS_OVER_BASE:    cfg_q.eps_over_base      <= cfg_data_i[30:0];
        CFG_EPS_EXTENDED:     cfg_q.eps_extended       <= cfg_data_i[30:0];
        CFG_EPS_WRIST_PAR:    cfg_q.eps_wrist_parallel <= cfg_data_i[30:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= '0;
    end else if (accept) begin
      gap_q <= 3'(ITEM_CYCLES - 1);
    end else if (busy) begin
      gap_q <= gap_q - 3'd1;
    end
  end

  assign ph[0] = {{16{cmd_i.angle_1[15]}}, cmd_i.angle_1} << (32 - ANGLE_BITS);
  assign ph[1] = {{16{cmd_i.angle_2[15]}}, cmd_i.angle_2} << (32 - ANGLE_BITS);
  assign ph[2] = {{16{cmd_i.angle_3[15]}}, cmd_i.angle_3} << (32 - ANGLE_BITS);
  assign ph[3] = {{16{cmd_i.angle_4[15]}}, cmd_i.angle_4} << (32 - ANGLE_BITS);
  assign ph[4] = {{16{cmd_i.angle_5[15]}}, cmd_i.angle_5} << (32 - ANGLE_BITS);
  assign ph[5] = {{16{cmd_i.angle_6[15]}}, cmd_i.angle_6} << (32 - ANGLE_BITS);

  assign lane_ph[0] = ph[0];
  assign lane_ph[1] = ph[1];
  assign lane_ph[2] = ph[1] + ph[2];
  assign lane_ph[3] = ph[3];
  assign lane_ph[4] = ph[4];
  assign lane_ph[5] = ph[5];

  for (genvar j = 0; j < Lanes; j++) begin : g_lane
    fkv_cordic #(
      .TRIG_ITERATIONS(TRIG_ITERATIONS)
    ) u_cordic (
      .clk_i  (clk_i),
      .phase_i(lane_ph[j]),
      .cos_o  (cos_w[j]),
      .sin_o  (sin_w[j])
    );
  end

  assign dly_d.rate.rate_1 = cmd_i.rate_1;
  assign dly_d.rate.rate_2 = cmd_i.rate_2;
  assign dly_d.rate.rate_3 = cmd_i.rate_3;
  assign dly_d.rate.rate_4 = cmd_i.rate_4;
  assign dly_d.rate.rate_5 = cmd_i.rate_5;
  assign dly_d.rate.rate_6 = cmd_i.rate_6;
  assign dly_d.flip        = ph[4][31];
  assign dly_d.elbow       = ph[2][31];

  always_ff @(posedge clk_i) begin
    dly_q[0] <= dly_d;
    for (int k = 1; k < CordicLat; k++) begin
      dly_q[k] <= dly_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvld_q <= '0;
    end else begin
      dvld_q <= {dvld_q[CordicLat-2:0], accept};
    end
  end

  assign kin_in.trig.c1  = cos_w[0];
  assign kin_in.trig.s1  = sin_w[0];
  assign kin_in.trig.c2  = cos_w[1];
  assign kin_in.trig.s2  = sin_w[1];
  assign kin_in.trig.c23 = cos_w[2];
  assign kin_in.trig.s23 = sin_w[2];
  assign kin_in.trig.c4  = cos_w[3];
  assign kin_in.trig.s4  = sin_w[3];
  assign kin_in.trig.c5  = cos_w[4];
  assign kin_in.trig.s5  = sin_w[4];
  assign kin_in.trig.c6  = cos_w[5];
  assign kin_in.trig.s6  = sin_w[5];
  assign kin_in.rate     = dly_q[CordicLat-1].rate;
  assign kin_in.flip     = dly_q[CordicLat-1].flip;
  assign kin_in.elbow    = dly_q[CordicLat-1].elbow;

  fkv_kin u_kin (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(dvld_q[CordicLat-1]),
    .kin_i  (kin_in),
    .cfg_i  (cfg_q),
    .valid_o(kin_vld),
    .res_o  (kin_res)
  );

  always_ff @(posedge clk_i) begin
    if (kin_vld) begin
      hold_q <= kin_res;
    end
    res_q.item_kind   <= cnt_q;
    res_q.comp_x      <= hold_q.item[cnt_q].x;
    res_q.comp_y      <= hold_q.item[cnt_q].y;
    res_q.comp_z      <= hold_q.item[cnt_q].z;
    res_q.status_bits <= hold_q.status;
    res_q.singular    <= |hold_q.status[6:3];
    res_q.last        <= cnt_q == KIND_ANG;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      act_q    <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= act_q;
      if (kin_vld) begin
        cnt_q <= KIND_ROT0;
        act_q <= 1'b1;
      end else if (act_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == KIND_ANG) begin
          act_q <= 1'b0;
        end
      end
    end
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

  `FKV_ASSERT_NEXT(a_busy_after_accept, accept, busy)
  `FKV_ASSERT_NEXT(a_run_continues, res_strobe_o && res_o.item_kind != KIND_ANG, res_strobe_o)
  `FKV_ASSERT_NEXT(a_run_restarts, res_strobe_o && res_o.last, !res_strobe_o || res_o.item_kind == KIND_ROT0)
  `FKV_ASSERT_IMPLIES(a_status_steady, res_strobe_o && res_o.item_kind != KIND_ROT0, res_o.status_bits == $past(res_o.status_bits))

endmodule

// ----- rtl/fkv_cordic.sv -----
module fkv_cordic #(
  parameter int unsigned TRIG_ITERATIONS = fkv_pkg::TRIG_ITERATIONS_DEF
) (
  input  logic               clk_i,
  input  logic [31:0]        phase_i,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);
  import fkv_pkg::*;

  localparam int unsigned Cw = 34;

  logic [31:0]            ph_fold;
  logic                   neg_q [TRIG_ITERATIONS+1];
  logic signed [Cw-1:0]   x_q [TRIG_ITERATIONS+1];
  logic signed [Cw-1:0]   y_q [TRIG_ITERATIONS+1];
  logic signed [Cw-1:0]   z_q [TRIG_ITERATIONS+1];
  logic signed [Cw-1:0]   xc, yc;
  logic signed [31:0]     cos_q, sin_q;

  // Quadrants one and two are folded by a half turn and negated at the end.
  assign ph_fold = (phase_i[31] ^ phase_i[30]) ? phase_i + 32'h8000_0000 : phase_i;

  always_ff @(posedge clk_i) begin
    neg_q[0] <= phase_i[31] ^ phase_i[30];
    x_q[0]   <= KINV30;
    y_q[0]   <= '0;
    z_q[0]   <= {{(Cw-32){ph_fold[31]}}, ph_fold};
  end

  for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_iter
    logic signed [Cw-1:0] atan_w;
    assign atan_w = {{(Cw-32){1'b0}}, ATAN_PHASE[i]};
    always_ff @(posedge clk_i) begin
      neg_q[i+1] <= neg_q[i];
      if (!z_q[i][Cw-1]) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - atan_w;
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + atan_w;
      end
    end
  end

  always_comb begin
    xc = x_q[TRIG_ITERATIONS];
    yc = y_q[TRIG_ITERATIONS];
    if (xc > ONE30) xc = ONE30;
    if (xc < -ONE30) xc = -ONE30;
    if (yc > ONE30) yc = ONE30;
    if (yc < -ONE30) yc = -ONE30;
    if (neg_q[TRIG_ITERATIONS]) begin
      xc = -xc;
      yc = -yc;
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q <= xc[31:0];
    sin_q <= yc[31:0];
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

// ----- rtl/fkv_kin.sv -----
module fkv_kin (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  fkv_pkg::kin_in_t   kin_i,
  input  fkv_pkg::cfg_t      cfg_i,
  output logic               valid_o,
  output fkv_pkg::kin_res_t  res_o
);
  import fkv_pkg::*;

  typedef struct packed {
    w_t c1, s1, c2, s2, c23, s23, c4, s4, c5, s5, c6, s6;
    w_t qd1, qd2, qd3, qd4, qd5, qd6;
    w_t s5c6, s5s6, c4s5, s4s5, c1c23, c1s23, s1c23, s1s23;
    w_t s4c5, c4c5, c4c6, s4c6, c4s6, s4s6;
    w_t lc, ls, c2l2, s2l2, s4qd5, c5qd6, c4qd5;
    w_t a0, b0, a1, b1;
    w_t r00, r10, r20, r01, r11, r21, r02, r12, r22;
    w_t dwv, dwh, wwz, c4s5qd6, s4s5qd6;
    w_t px6, py6, pz6, s1dwh, c1dwh, dwv2, dwh2;
    w_t wwy, wx, vx, dwvqd2, lcqd3, dwhqd2, lsqd3, c23wwz, s23wwz;
    w_t pos0, pos1, pos2, wy, w2, vy, c1vx, s1vx, c1wx, s1wx;
    w_t w0, w1, c1vy, s1vy, w2py6, w2px6;
    w_t v0, v1, v2;
    logic [6:0] st;
  } pipe_t;

  pipe_t p0_d, p1_d, p2_d, p3_d, p4_d, p5_d;
  pipe_t p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic [KIN_STAGES-1:0] vld_q;
  w_t l1, l2, l3, l6, eps_ob, eps_wp;

  assign l1     = w_t'(cfg_i.base_height);
  assign l2     = w_t'(cfg_i.upper_arm_length);
  assign l3     = w_t'(cfg_i.forearm_length);
  assign l6     = w_t'(cfg_i.tool_length);
  assign eps_ob = w_t'(cfg_i.eps_over_base);
  assign eps_wp = w_t'(cfg_i.eps_wrist_parallel);

  always_comb begin
    pipe_t s;
    s       = '0;
    s.c1    = w_t'(kin_i.trig.c1);
    s.s1    = w_t'(kin_i.trig.s1);
    s.c2    = w_t'(kin_i.trig.c2);
    s.s2    = w_t'(kin_i.trig.s2);
    s.c23   = w_t'(kin_i.trig.c23);
    s.s23   = w_t'(kin_i.trig.s23);
    s.c4    = w_t'(kin_i.trig.c4);
    s.s4    = w_t'(kin_i.trig.s4);
    s.c5    = w_t'(kin_i.trig.c5);
    s.s5    = w_t'(kin_i.trig.s5);
    s.c6    = w_t'(kin_i.trig.c6);
    s.s6    = w_t'(kin_i.trig.s6);
    s.qd1   = w_t'(kin_i.rate.rate_1);
    s.qd2   = w_t'(kin_i.rate.rate_2);
    s.qd3   = w_t'(kin_i.rate.rate_3);
    s.qd4   = w_t'(kin_i.rate.rate_4);
    s.qd5   = w_t'(kin_i.rate.rate_5);
    s.qd6   = w_t'(kin_i.rate.rate_6);
    s.s5c6  = mul30(s.s5, s.c6);
    s.s5s6  = mul30(s.s5, s.s6);
    s.c4s5  = mul30(s.c4, s.s5);
    s.s4s5  = mul30(s.s4, s.s5);
    s.c1c23 = mul30(s.c1, s.c23);
    s.c1s23 = mul30(s.c1, s.s23);
    s.s1c23 = mul30(s.s1, s.c23);
    s.s1s23 = mul30(s.s1, s.s23);
    s.s4c5  = mul30(s.s4, s.c5);
    s.c4c5  = mul30(s.c4, s.c5);
    s.c4c6  = mul30(s.c4, s.c6);
    s.s4c6  = mul30(s.s4, s.c6);
    s.c4s6  = mul30(s.c4, s.s6);
    s.s4s6  = mul30(s.s4, s.s6);
    s.lc    = sat32(mul30(s.c23, l3));
    s.ls    = sat32(mul30(s.s23, l3));
    s.c2l2  = mul30(s.c2, l2);
    s.s2l2  = mul30(s.s2, l2);
    s.s4qd5 = mul30(s.s4, s.qd5);
    s.c5qd6 = mul30(s.c5, s.qd6);
    s.c4qd5 = mul30(s.c4, s.qd5);
    s.st[1] = kin_i.flip;
    s.st[2] = kin_i.elbow;
    s.st[6] = absw(s.s5) < eps_wp;
    p0_d    = s;
  end

  always_comb begin
    pipe_t s;
    s         = p0_q;
    s.a0      = mul30(s.s4c5, s.s6) - s.c4c6;
    s.b0      = mul30(s.c4c5, s.s6) + s.s4c6;
    s.a1      = mul30(s.s4c5, s.c6) + s.c4s6;
    s.b1      = mul30(s.c4c5, s.c6) - s.s4s6;
    s.r02     = -mul30(s.s1c23, s.c4s5) - mul30(s.c1, s.s4s5) - mul30(s.s1s23, s.c5);
    s.r12     = mul30(s.c1c23, s.c4s5) - mul30(s.s1, s.s4s5) + mul30(s.c1s23, s.c5);
    s.r22     = -mul30(s.s23, s.c4s5) + mul30(s.c23, s.c5);
    s.dwv     = sat32(s.c2l2 + s.lc);
    s.dwh     = sat32(s.s2l2 + s.ls);
    s.wwz     = sat32(s.qd4 + s.c5qd6);
    s.c4s5qd6 = mul30(s.c4s5, s.qd6);
    s.s4s5qd6 = mul30(s.s4s5, s.qd6);
    p1_d      = s;
  end

  always_comb begin
    pipe_t s;
    s        = p1_q;
    s.r00    = -mul30(s.s1c23, s.b0) - mul30(s.c1, s.a0) + mul30(s.s1s23, s.s5s6);
    s.r10    = mul30(s.c1c23, s.b0) - mul30(s.s1, s.a0) - mul30(s.c1s23, s.s5s6);
    s.r20    = -mul30(s.s23, s.b0) - mul30(s.c23, s.s5s6);
    s.r01    = -mul30(s.s1c23, s.b1) - mul30(s.c1, s.a1) + mul30(s.s1s23, s.s5c6);
    s.r11    = mul30(s.c1c23, s.b1) - mul30(s.s1, s.a1) - mul30(s.c1s23, s.s5c6);
    s.r21    = -mul30(s.s23, s.b1) - mul30(s.c23, s.s5c6);
    s.px6    = sat32(mul30(s.r02, l6));
    s.py6    = sat32(mul30(s.r12, l6));
    s.pz6    = sat32(mul30(s.r22, l6));
    s.s1dwh  = mul30(s.s1, s.dwh);
    s.c1dwh  = mul30(s.c1, s.dwh);
    s.dwv2   = s.dwv * s.dwv;
    s.dwh2   = s.dwh * s.dwh;
    s.st[0]  = s.dwh < 0;
    s.st[3]  = absw(s.dwh) < eps_ob;
    s.wwy    = sat32(-s.s4qd5 + s.c4s5qd6);
    s.wx     = sat32(-s.c4qd5 - s.s4s5qd6 - s.qd2 - s.qd3);
    s.vx     = sat32(-mul16(s.dwh, s.qd1));
    s.dwvqd2 = mul16(s.dwv, s.qd2);
    s.lcqd3  = mul16(s.lc, s.qd3);
    s.dwhqd2 = mul16(s.dwh, s.qd2);
    s.lsqd3  = mul16(s.ls, s.qd3);
    s.c23wwz = mul30(s.c23, s.wwz);
    s.s23wwz = mul30(s.s23, s.wwz);
    p2_d     = s;
  end

  always_comb begin
    pipe_t s;
    logic [64:0] rsq;
    logic [64:0] e2;
    logic [64:0] lim;
    s      = p2_q;
    rsq    = {1'b0, s.dwv2} + {1'b0, s.dwh2};
    e2     = 65'(cfg_i.eps_extended) * 65'(cfg_i.eps_extended);
    lim    = 65'(cfg_i.reach_limit_sq);
    s.st[4] = (rsq + e2) > lim;
    s.st[5] = ((rsq + e2) > lim) && (rsq > lim);
    s.pos0 = sat32(s.px6 + sat32(-s.s1dwh));
    s.pos1 = sat32(s.py6 + sat32(s.c1dwh));
    s.pos2 = sat32(s.pz6 + sat32(l1 + s.dwv));
    s.wy   = sat32(mul30(s.c23, s.wwy) + s.s23wwz);
    s.w2   = sat32(s.qd1 + s.c23wwz - mul30(s.s23, s.wwy));
    s.vy   = sat32(s.dwvqd2 + s.lcqd3);
    s.c1vx = mul30(s.c1, s.vx);
    s.s1vx = mul30(s.s1, s.vx);
    s.c1wx = mul30(s.c1, s.wx);
    s.s1wx = mul30(s.s1, s.wx);
    p3_d   = s;
  end

  always_comb begin
    pipe_t s;
    s       = p3_q;
    s.w0    = sat32(s.c1wx - mul30(s.s1, s.wy));
    s.w1    = sat32(mul30(s.c1, s.wy) + s.s1wx);
    s.c1vy  = mul30(s.c1, s.vy);
    s.s1vy  = mul30(s.s1, s.vy);
    s.w2py6 = mul16(s.w2, s.py6);
    s.w2px6 = mul16(s.w2, s.px6);
    p4_d    = s;
  end

  always_comb begin
    pipe_t s;
    s    = p4_q;
    s.v0 = s.c1vx - s.s1vy + mul16(s.w1, s.pz6) - s.w2py6;
    s.v1 = s.c1vy + s.s1vx + s.w2px6 - mul16(s.w0, s.pz6);
    s.v2 = -s.dwhqd2 - s.lsqd3 + mul16(s.w0, s.py6) - mul16(s.w1, s.px6);
    p5_d = s;
  end

  always_ff @(posedge clk_i) begin
    p0_q <= p0_d;
    p1_q <= p1_d;
    p2_q <= p2_d;
    p3_q <= p3_d;
    p4_q <= p4_d;
    p5_q <= p5_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[KIN_STAGES-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[KIN_STAGES-1];

  always_comb begin
    res_o.item[KIND_ROT0].x = 32'(sat32(p5_q.r00));
    res_o.item[KIND_ROT0].y = 32'(sat32(p5_q.r10));
    res_o.item[KIND_ROT0].z = 32'(sat32(p5_q.r20));
    res_o.item[KIND_ROT1].x = 32'(sat32(p5_q.r01));
    res_o.item[KIND_ROT1].y = 32'(sat32(p5_q.r11));
    res_o.item[KIND_ROT1].z = 32'(sat32(p5_q.r21));
    res_o.item[KIND_ROT2].x = 32'(sat32(p5_q.r02));
    res_o.item[KIND_ROT2].y = 32'(sat32(p5_q.r12));
    res_o.item[KIND_ROT2].z = 32'(sat32(p5_q.r22));
    res_o.item[KIND_POS].x  = 32'(p5_q.pos0);
    res_o.item[KIND_POS].y  = 32'(p5_q.pos1);
    res_o.item[KIND_POS].z  = 32'(p5_q.pos2);
    res_o.item[KIND_LIN].x  = 32'(sat32(p5_q.v0));
    res_o.item[KIND_LIN].y  = 32'(sat32(p5_q.v1));
    res_o.item[KIND_LIN].z  = 32'(sat32(p5_q.v2));
    res_o.item[KIND_ANG].x  = 32'(p5_q.w0);
    res_o.item[KIND_ANG].y  = 32'(p5_q.w1);
    res_o.item[KIND_ANG].z  = 32'(p5_q.w2);
    res_o.status            = p5_q.st;
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import fkv_pkg::*;

  class kin_scoreboard;
    res_t pending_q[$];
    int   fail_count;
    int   cmd_count;
    int   res_count;

    function void note_cmd(res_t items[6]);
      for (int i = 0; i < 6; i++) pending_q.push_back(items[i]);
      cmd_count++;
    endfunction

    function void check_res(res_t got);
      res_t exp_r;
      res_count++;
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result: got %h", $time, got);
        fail_count++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.item_kind !== exp_r.item_kind)
        report("item_kind", exp_r.item_kind, got.item_kind);
      if (got.comp_x !== exp_r.comp_x) report("comp_x", exp_r.comp_x, got.comp_x);
      if (got.comp_y !== exp_r.comp_y) report("comp_y", exp_r.comp_y, got.comp_y);
      if (got.comp_z !== exp_r.comp_z) report("comp_z", exp_r.comp_z, got.comp_z);
      if (got.status_bits !== exp_r.status_bits)
        report("status_bits", exp_r.status_bits, got.status_bits);
      if (got.singular !== exp_r.singular)
        report("singular", exp_r.singular, got.singular);
      if (got.last !== exp_r.last) report("last", exp_r.last, got.last);
    endfunction

    function void report(string fld, logic [63:0] e, logic [63:0] a);
      $display("%0t mismatch %s: expected %h actual %h", $time, fld, e, a);
      fail_count++;
    endfunction
  endclass

  localparam int AB = ANGLE_BITS_DEF;
  localparam int NIT = TRIG_ITERATIONS_DEF;
  localparam int LATENCY = NIT + 9 + 6;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  cmd_t        cmd_i;
  logic        busy;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [62:0] cfg_data_i;
  logic        res_strobe_o;
  res_t        res_o;

  fwd_kin_vel_6r_wrist_arm_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .cmd_i(cmd_i), .busy(busy),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .res_strobe_o(res_strobe_o), .res_o(res_o)
  );

  kin_scoreboard sb = new();

  logic [30:0] len_base, len_upper, len_fore, len_tool;
  logic [62:0] reach_sq;
  logic [30:0] thr_over, thr_ext, thr_par;

  longint unsigned cycle_count;
  int idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && res_strobe_o === 1'b1) sb.check_res(res_o);

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint q16_mul(longint a, longint b);
    return (a * b + (64'sd1 <<< 15)) >>> 16;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [31:0] angle_phase(logic signed [15:0] a);
    longint v;
    v = a;
    return 32'(v <<< (32 - AB));
  endfunction

  task automatic sincos(input logic [31:0] ph, output longint c, output longint s);
    logic [1:0] quad;
    logic       neg;
    longint     x, y, z, t;
    quad = ph[31:30];
    neg = (quad == 2'd1 || quad == 2'd2);
    x = KINV30;
    y = 0;
    if (neg) ph = ph + 32'h80000000;
    z = longint'($signed(ph));
    for (int i = 0; i < NIT && i < 30; i++) begin
      if (z >= 0) begin
        t = x - shr(y, i);
        y = y + shr(x, i);
        z = z - longint'(ATAN_PHASE[i]);
      end else begin
        t = x + shr(y, i);
        y = y - shr(x, i);
        z = z + longint'(ATAN_PHASE[i]);
      end
      x = t;
    end
    if (x > ONE30) x = ONE30;
    if (x < -ONE30) x = -ONE30;
    if (y > ONE30) y = ONE30;
    if (y < -ONE30) y = -ONE30;
    c = neg ? -x : x;
    s = neg ? -y : y;
  endtask

  task automatic predict_pose(input cmd_t cmd, output res_t items[6]);
    logic [31:0] p1, p2, p3, p4, p5, p6;
    longint qd1, qd2, qd3, qd4, qd5, qd6, l1, l2, l3, l6;
    longint c1, s1, c2, s2, c23, s23, c4, s4, c5, s5, c6, s6;
    longint s5c6, s5s6, c4s5, s4s5, c1c23, c1s23, s1c23, s1s23, ta, tb;
    longint r00, r10, r20, r01, r11, r21, r02, r12, r22;
    longint dwv, dwh, px6, py6, pz6, pos0, pos1, pos2;
    longint wwy, wwz, wx, wy, w0, w1, w2, vx, vy, v0, v1, v2, lc, ls;
    logic [63:0] rsq, e2, sum;
    logic [6:0] st;
    logic sg;
    longint vals[6][3];
    p1 = angle_phase(cmd.angle_1); p2 = angle_phase(cmd.angle_2);
    p3 = angle_phase(cmd.angle_3); p4 = angle_phase(cmd.angle_4);
    p5 = angle_phase(cmd.angle_5); p6 = angle_phase(cmd.angle_6);
    qd1 = cmd.rate_1; qd2 = cmd.rate_2; qd3 = cmd.rate_3;
    qd4 = cmd.rate_4; qd5 = cmd.rate_5; qd6 = cmd.rate_6;
    l1 = len_base; l2 = len_upper; l3 = len_fore; l6 = len_tool;
    sincos(p1, c1, s1);
    sincos(p2, c2, s2);
    sincos(p2 + p3, c23, s23);
    sincos(p4, c4, s4);
    sincos(p5, c5, s5);
    sincos(p6, c6, s6);
    s5c6 = q30_mul(s5, c6); s5s6 = q30_mul(s5, s6);
    c4s5 = q30_mul(c4, s5); s4s5 = q30_mul(s4, s5);
    c1c23 = q30_mul(c1, c23); c1s23 = q30_mul(c1, s23);
    s1c23 = q30_mul(s1, c23); s1s23 = q30_mul(s1, s23);
    ta = q30_mul(q30_mul(s4, c5), s6) - q30_mul(c4, c6);
    tb = q30_mul(q30_mul(c4, c5), s6) + q30_mul(s4, c6);
    r00 = -q30_mul(s1c23, tb) - q30_mul(c1, ta) + q30_mul(s1s23, s5s6);
    r10 = q30_mul(c1c23, tb) - q30_mul(s1, ta) - q30_mul(c1s23, s5s6);
    r20 = -q30_mul(s23, tb) - q30_mul(c23, s5s6);
    ta = q30_mul(q30_mul(s4, c5), c6) + q30_mul(c4, s6);
    tb = q30_mul(q30_mul(c4, c5), c6) - q30_mul(s4, s6);
    r01 = -q30_mul(s1c23, tb) - q30_mul(c1, ta) + q30_mul(s1s23, s5c6);
    r11 = q30_mul(c1c23, tb) - q30_mul(s1, ta) - q30_mul(c1s23, s5c6);
    r21 = -q30_mul(s23, tb) - q30_mul(c23, s5c6);
    r02 = -q30_mul(s1c23, c4s5) - q30_mul(c1, s4s5) - q30_mul(s1s23, c5);
    r12 = q30_mul(c1c23, c4s5) - q30_mul(s1, s4s5) + q30_mul(c1s23, c5);
    r22 = -q30_mul(s23, c4s5) + q30_mul(c23, c5);
    lc = clamp32(q30_mul(c23, l3));
    ls = clamp32(q30_mul(s23, l3));
    dwv = clamp32(q30_mul(c2, l2) + lc);
    dwh = clamp32(q30_mul(s2, l2) + ls);
    px6 = clamp32(q30_mul(r02, l6));
    py6 = clamp32(q30_mul(r12, l6));
    pz6 = clamp32(q30_mul(r22, l6));
    pos0 = clamp32(px6 + clamp32(-q30_mul(s1, dwh)));
    pos1 = clamp32(py6 + clamp32(q30_mul(c1, dwh)));
    pos2 = clamp32(pz6 + clamp32(l1 + dwv));
    st = '0;
    if (dwh < 0) st[0] = 1'b1;
    if (p5[31]) st[1] = 1'b1;
    if (p3[31]) st[2] = 1'b1;
    if (mag(dwh) < longint'(thr_over)) st[3] = 1'b1;
    rsq = 64'(dwv * dwv) + 64'(dwh * dwh);
    e2 = 64'(thr_ext) * 64'(thr_ext);
    sum = rsq + e2;
    if (sum > 64'(reach_sq)) begin
      st[4] = 1'b1;
      if (rsq > 64'(reach_sq)) st[5] = 1'b1;
    end
    if (mag(s5) < longint'(thr_par)) st[6] = 1'b1;
    sg = |st[6:3];
    wwy = clamp32(-q30_mul(s4, qd5) + q30_mul(c4s5, qd6));
    wwz = clamp32(qd4 + q30_mul(c5, qd6));
    wx = clamp32(-q30_mul(c4, qd5) - q30_mul(s4s5, qd6) - qd2 - qd3);
    wy = clamp32(q30_mul(c23, wwy) + q30_mul(s23, wwz));
    w0 = clamp32(q30_mul(c1, wx) - q30_mul(s1, wy));
    w1 = clamp32(q30_mul(c1, wy) + q30_mul(s1, wx));
    w2 = clamp32(qd1 + q30_mul(c23, wwz) - q30_mul(s23, wwy));
    vx = clamp32(-q16_mul(dwh, qd1));
    vy = clamp32(q16_mul(dwv, qd2) + q16_mul(lc, qd3));
    v0 = q30_mul(c1, vx) - q30_mul(s1, vy) + q16_mul(w1, pz6) - q16_mul(w2, py6);
    v1 = q30_mul(c1, vy) + q30_mul(s1, vx) + q16_mul(w2, px6) - q16_mul(w0, pz6);
    v2 = -q16_mul(dwh, qd2) - q16_mul(ls, qd3) + q16_mul(w0, py6) - q16_mul(w1, px6);
    vals = '{'{r00, r10, r20}, '{r01, r11, r21}, '{r02, r12, r22},
             '{pos0, pos1, pos2}, '{v0, v1, v2}, '{w0, w1, w2}};
    for (int k = 0; k < 6; k++) begin
      items[k].item_kind = 3'(k);
      items[k].comp_x = 32'(clamp32(vals[k][0]));
      items[k].comp_y = 32'(clamp32(vals[k][1]));
      items[k].comp_z = 32'(clamp32(vals[k][2]));
      items[k].status_bits = st;
      items[k].singular = sg;
      items[k].last = (k == KIND_ANG);
    end
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [62:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_BASE_HEIGHT:      len_base = val[30:0];
      CFG_UPPER_ARM_LENGTH: len_upper = val[30:0];
      CFG_FOREARM_LENGTH:   len_fore = val[30:0];
      CFG_TOOL_LENGTH:      len_tool = val[30:0];
      CFG_REACH_LIMIT_SQ:   reach_sq = val;
      CFG_EPS_OVER_BASE:    thr_over = val[30:0];
      CFG_EPS_EXTENDED:     thr_ext = val[30:0];
      default:              thr_par = val[30:0];
    endcase
  endtask

  task automatic drain;
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic configure(input logic [30:0] lb, lu, lf, lt, input logic [62:0] rl,
                           input logic [30:0] eo, ee, ep);
    drain();
    write_reg(CFG_BASE_HEIGHT, 63'(lb));
    write_reg(CFG_UPPER_ARM_LENGTH, 63'(lu));
    write_reg(CFG_FOREARM_LENGTH, 63'(lf));
    write_reg(CFG_TOOL_LENGTH, 63'(lt));
    write_reg(CFG_REACH_LIMIT_SQ, rl);
    write_reg(CFG_EPS_OVER_BASE, 63'(eo));
    write_reg(CFG_EPS_EXTENDED, 63'(ee));
    write_reg(CFG_EPS_WRIST_PAR, 63'(ep));
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_cmd(input cmd_t cmd);
    res_t items[6];
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= cmd;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    predict_pose(cmd, items);
    sb.note_cmd(items);
  endtask

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(($urandom_range(3) * 16384) + $urandom_range(2) - 1);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_rate();
    case ($urandom_range(7))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2, 3: return $urandom;
      default: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c.angle_1 = rand_angle(); c.angle_2 = rand_angle(); c.angle_3 = rand_angle();
    c.angle_4 = rand_angle(); c.angle_5 = rand_angle(); c.angle_6 = rand_angle();
    c.rate_1 = rand_rate(); c.rate_2 = rand_rate(); c.rate_3 = rand_rate();
    c.rate_4 = rand_rate(); c.rate_5 = rand_rate(); c.rate_6 = rand_rate();
    return c;
  endfunction

  function automatic cmd_t fill_cmd(input logic [15:0] a, input logic [31:0] r);
    return '{a, a, a, a, a, a, r, r, r, r, r, r};
  endfunction

  initial begin
    cmd_t c;
    cycle_count = 0;
    idle_pct = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_BASE_HEIGHT;
    cfg_data_i = '0;
    len_base = '0; len_upper = '0; len_fore = '0; len_tool = '0;
    reach_sq = '0; thr_over = '0; thr_ext = '0; thr_par = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_cmd(fill_cmd(16'h0000, 32'h0));
    configure(31'h0000_8000, 31'h0001_0000, 31'h0000_C000, 31'h0000_2000,
              63'h0000_0003_0000_0000, 31'h0000_0400, 31'h0000_1000, 31'h0100_0000);
    send_cmd(fill_cmd(16'h0000, 32'h0001_0000));
    send_cmd(fill_cmd(16'h8000, 32'h8000_0000));
    send_cmd(fill_cmd(16'h7FFF, 32'h7FFF_FFFF));
    send_cmd(fill_cmd(16'hFFFF, 32'hFFFF_FFFF));
    send_cmd(fill_cmd(16'h4000, 32'h0000_0001));
    send_cmd(fill_cmd(16'hC000, 32'hFFFF_0000));
    send_cmd(fill_cmd(16'h2000, 32'h5555_5555));
    send_cmd(fill_cmd(16'hA000, 32'hAAAA_AAAA));
    c = fill_cmd(16'h1000, 32'h0002_0000);
    c.angle_3 = 16'hF000;
    c.angle_5 = 16'h0000;
    send_cmd(c);
    c.angle_2 = 16'h0000; c.angle_3 = 16'h0000;
    send_cmd(c);

    configure('1, '1, '1, '1, '1, '1, '1, 31'h4000_0000);
    send_cmd(fill_cmd(16'h1234, 32'h7FFF_FFFF));
    send_cmd(fill_cmd(16'hE000, 32'h8000_0000));
    send_cmd(rand_cmd());

    configure(31'h0001_0000, 31'h0004_0000, 31'h0003_0000, 31'h0000_8000,
              63'h0000_0000_1000_0000, 31'h0, 31'h0100_0000, 31'h0);
    send_cmd(fill_cmd(16'h0000, 32'h0001_0000));
    send_cmd(fill_cmd(16'h3000, 32'hFFF0_0000));

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 81 : (ph == 2) ? 31 : 0;
      configure(31'($urandom_range(32'h0008_0000)), 31'($urandom_range(32'h0008_0000)),
                31'($urandom_range(32'h0008_0000)), 31'($urandom_range(32'h0004_0000)),
                63'({$urandom, $urandom} >> $urandom_range(1, 20)),
                31'($urandom_range(32'h0002_0000)), 31'($urandom_range(32'h0004_0000)),
                31'($urandom_range(32'h4000_0000)));
      for (int n = 0; n < 28; n++) begin
        send_cmd(rand_cmd());
        if (ph == 3 && n == 14) begin
          start <= 1'b0;
          while (sb.pending_q.size() != 0) @(posedge clk_i);
        end
      end
    end

    idle_pct = 0;
    configure(31'({$urandom, $urandom}), 31'({$urandom, $urandom}),
              31'({$urandom, $urandom}), 31'({$urandom, $urandom}),
              63'({$urandom, $urandom}), 31'({$urandom, $urandom}),
              31'({$urandom, $urandom}), 31'({$urandom, $urandom}));
    for (int n = 0; n < 10; n++) send_cmd(rand_cmd());

    drain();
    $display("Covered %0d commands and %0d result transactions over nine register settings,",
             sb.cmd_count, sb.res_count);
    $display("including extreme lengths, thresholds, angles and rates.");
    if (sb.fail_count == 0 && sb.pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
